// ===== rtl/ufr_pkg.sv =====
// shared types, constants and the crc-8/maxim byte update for the frame receiver
// no dependencies; used by the top level and the testbench
`default_nettype none

package ufr_pkg;

  // largest accepted length byte
  localparam logic [7:0] MAX_LEN = 8'd64;

  // framing bytes
  localparam logic [7:0] START_BYTE = 8'h7E;
  localparam logic [7:0] STOP_BYTE  = 8'hE7;
  localparam logic [7:0] ESC_BYTE   = 8'hAA;
  localparam logic [7:0] ESC_MASK   = 8'h02;
  localparam logic [7:0] MIN_LEN    = 8'd2;

  // reflected polynomial of crc-8/maxim
  localparam logic [7:0] CRC_POLY_REFL = 8'h8C;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_RECV = 2'd1,
    PH_HOLD = 2'd2
  } phase_t;

  typedef enum logic {
    OP_BYTE    = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_RESTART = 2'd1,
    ACT_DONE    = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_OK      = 2'd1,
    ST_CRC_BAD = 2'd2,
    ST_FRAMING = 2'd3
  } status_t;

  // one result item
  typedef struct packed {
    logic [1:0] action;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [1:0] frame_status;
    logic [7:0] payload_length;
  } result_t;

  // one byte through the crc, bit at a time, lsb first
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY_REFL) : (v >> 1);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ufr_if.sv =====
// valid/ready channel interfaces: received items, result items, config writes
// payload widths follow the field list; no package dependency
`default_nettype none

// received item channel
interface ufr_item_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

// result item channel
interface ufr_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic [1:0] frame_status;
  logic [7:0] payload_length;

  modport source (output valid, output action, output payload_valid, output payload_byte,
                  output frame_status, output payload_length, input ready);
  modport sink   (input valid, input action, input payload_valid, input payload_byte,
                  input frame_status, input payload_length, output ready);
endinterface

// configuration write channel, one register
interface ufr_cfg_if;
  logic valid;
  logic ready;
  logic check_crc;

  modport source (output valid, output check_crc, input ready);
  modport sink   (input valid, input check_crc, output ready);
endinterface

`default_nettype wire

// ===== rtl/uart_frame_receiver_crc8.sv =====
// byte-stuffed frame receiver with crc-8/maxim check, top level
// depends on ufr_pkg and the channel interfaces in ufr_if.sv
`default_nettype none

// Takes one received byte (or a release) per cycle and returns exactly one
// result item for each. Every item is finished in the cycle it is accepted:
// frame state and the crc byte update are plain logic between the state
// registers and a two-entry result buffer, so a new item is taken every
// cycle while the buffer has room. Item ready drops only while two results
// wait to be taken. Frames are start 0x7E, length L (2..64), L-2 data bytes
// with 0xAA escapes, crc byte, stop 0xE7; after the stop byte, with the crc
// good or bad, bytes are ignored until a release item. The check_crc
// register (reset 1) is always ready.
module uart_frame_receiver_crc8 (
  input  wire logic   clk,
  input  wire logic   rst,
  ufr_cfg_if.sink     cfg,
  ufr_item_if.sink    item,
  ufr_result_if.source result
);

  // frame state
  ufr_pkg::phase_t phase, phase_next;
  logic [7:0] byte_position, byte_position_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] running_crc, running_crc_next;
  logic       escape_pending, escape_pending_next;
  logic       crc_matched, crc_matched_next;
  logic [7:0] decoded_count, decoded_count_next;
  logic       check_crc;

  // result buffer
  ufr_pkg::result_t res_head, res_tail, res_new;
  logic [1:0] res_count;

  logic       item_xfer, result_xfer;
  logic [7:0] pos_inc;
  logic [7:0] crc_step;
  logic [7:0] b;
  logic       len_bad;

  assign item.ready = (res_count != 2'd2);
  assign item_xfer = item.valid && item.ready;
  assign result_xfer = result.valid && result.ready;
  assign cfg.ready = 1'b1;

  assign b = item.rx_byte;
  assign pos_inc = byte_position + 8'd1;
  assign crc_step = ufr_pkg::crc8_update((pos_inc == 8'd1) ? 8'd0 : running_crc, b);
  assign len_bad = (b < ufr_pkg::MIN_LEN) || (b > ufr_pkg::MAX_LEN);

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      check_crc <= 1'b1;
    end else if (cfg.valid && cfg.ready) begin
      check_crc <= cfg.check_crc;
    end
  end

  // next frame state
  always_comb begin
    phase_next = phase;
    byte_position_next = byte_position;
    frame_length_next = frame_length;
    running_crc_next = running_crc;
    escape_pending_next = escape_pending;
    crc_matched_next = crc_matched;
    decoded_count_next = decoded_count;
    if (item.operation == ufr_pkg::OP_RELEASE) begin
      phase_next = ufr_pkg::PH_HUNT;
      byte_position_next = 8'd0;
      frame_length_next = 8'd0;
      running_crc_next = 8'd0;
      escape_pending_next = 1'b0;
      crc_matched_next = 1'b0;
      decoded_count_next = 8'd0;
    end else begin
      case (phase)
        ufr_pkg::PH_RECV: begin
          byte_position_next = pos_inc;
          if (pos_inc == 8'd1) begin
            if (len_bad) begin
              phase_next = ufr_pkg::PH_HUNT;
              byte_position_next = 8'd0;
              frame_length_next = 8'd0;
              running_crc_next = 8'd0;
              escape_pending_next = 1'b0;
              crc_matched_next = 1'b0;
              decoded_count_next = 8'd0;
            end else begin
              frame_length_next = b;
              running_crc_next = crc_step;
            end
          end else if (pos_inc < frame_length) begin
            running_crc_next = crc_step;
            if (escape_pending) begin
              escape_pending_next = 1'b0;
              decoded_count_next = decoded_count + 8'd1;
            end else if (b == ufr_pkg::ESC_BYTE) begin
              escape_pending_next = 1'b1;
            end else begin
              decoded_count_next = decoded_count + 8'd1;
            end
          end else if (pos_inc == frame_length) begin
            crc_matched_next = (b == running_crc);
          end else if (b == ufr_pkg::STOP_BYTE) begin
            phase_next = ufr_pkg::PH_HOLD;
          end else begin
            phase_next = ufr_pkg::PH_HUNT;
            byte_position_next = 8'd0;
            frame_length_next = 8'd0;
            running_crc_next = 8'd0;
            escape_pending_next = 1'b0;
            crc_matched_next = 1'b0;
            decoded_count_next = 8'd0;
          end
        end
        ufr_pkg::PH_HOLD: begin
          phase_next = ufr_pkg::PH_HOLD;
        end
        default: begin
          phase_next = ufr_pkg::PH_HUNT;
          if (b == ufr_pkg::START_BYTE) begin
            phase_next = ufr_pkg::PH_RECV;
            byte_position_next = 8'd0;
            frame_length_next = 8'd0;
            running_crc_next = 8'd0;
            escape_pending_next = 1'b0;
            crc_matched_next = 1'b0;
            decoded_count_next = 8'd0;
          end
        end
      endcase
    end
  end

  // result fields for the item
  always_comb begin
    res_new.action = ufr_pkg::ACT_NONE;
    res_new.payload_valid = 1'b0;
    res_new.payload_byte = 8'd0;
    res_new.frame_status = ufr_pkg::ST_NONE;
    res_new.payload_length = 8'd0;
    if (item.operation == ufr_pkg::OP_BYTE) begin
      case (phase)
        ufr_pkg::PH_RECV: begin
          if (pos_inc == 8'd1) begin
            if (len_bad) begin
              res_new.frame_status = ufr_pkg::ST_FRAMING;
            end else begin
              res_new.action = ufr_pkg::ACT_RESTART;
            end
          end else if (pos_inc < frame_length) begin
            res_new.action = ufr_pkg::ACT_RESTART;
            if (escape_pending) begin
              res_new.payload_valid = 1'b1;
              res_new.payload_byte = b | ufr_pkg::ESC_MASK;
            end else if (b != ufr_pkg::ESC_BYTE) begin
              res_new.payload_valid = 1'b1;
              res_new.payload_byte = b;
            end
          end else if (pos_inc == frame_length) begin
            res_new.action = ufr_pkg::ACT_RESTART;
          end else begin
            res_new.payload_length = decoded_count;
            if (b == ufr_pkg::STOP_BYTE) begin
              res_new.action = ufr_pkg::ACT_DONE;
              res_new.frame_status = (check_crc && !crc_matched) ? ufr_pkg::ST_CRC_BAD
                                                                  : ufr_pkg::ST_OK;
            end else begin
              res_new.frame_status = ufr_pkg::ST_FRAMING;
            end
          end
        end
        ufr_pkg::PH_HOLD: begin
          res_new.action = ufr_pkg::ACT_NONE;
        end
        default: begin
          if (b == ufr_pkg::START_BYTE) begin
            res_new.action = ufr_pkg::ACT_RESTART;
          end
        end
      endcase
    end
  end

  // state update on item transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= ufr_pkg::PH_HUNT;
      byte_position <= 8'd0;
      frame_length <= 8'd0;
      running_crc <= 8'd0;
      escape_pending <= 1'b0;
      crc_matched <= 1'b0;
      decoded_count <= 8'd0;
    end else if (item_xfer) begin
      phase <= phase_next;
      byte_position <= byte_position_next;
      frame_length <= frame_length_next;
      running_crc <= running_crc_next;
      escape_pending <= escape_pending_next;
      crc_matched <= crc_matched_next;
      decoded_count <= decoded_count_next;
    end
  end

  // result buffer occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      res_count <= 2'd0;
    end else if (item_xfer && !result_xfer) begin
      res_count <= res_count + 2'd1;
    end else if (!item_xfer && result_xfer) begin
      res_count <= res_count - 2'd1;
    end
  end

  // result buffer payload
  always_ff @(posedge clk) begin
    case (res_count)
      2'd0: begin
        if (item_xfer) begin
          res_head <= res_new;
        end
      end
      2'd1: begin
        if (item_xfer && result_xfer) begin
          res_head <= res_new;
        end else if (item_xfer) begin
          res_tail <= res_new;
        end
      end
      default: begin
        if (result_xfer) begin
          res_head <= res_tail;
        end
      end
    endcase
  end

  assign result.valid = (res_count != 2'd0);
  assign result.action = res_head.action;
  assign result.payload_valid = res_head.payload_valid;
  assign result.payload_byte = res_head.payload_byte;
  assign result.frame_status = res_head.frame_status;
  assign result.payload_length = res_head.payload_length;

  // buffer never overfills
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    res_count != 2'd3)
    else $error("result buffer count out of range");

  // a frame-complete result always carries ok or crc mismatch
  a_done_status: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.action == ufr_pkg::ACT_DONE) |->
      (result.frame_status == ufr_pkg::ST_OK || result.frame_status == ufr_pkg::ST_CRC_BAD))
    else $error("frame complete without a good status");

  // payload bytes come only with a restart action
  a_payload_action: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.payload_valid) |-> result.action == ufr_pkg::ACT_RESTART)
    else $error("payload byte outside of data phase");

  // a frame-complete result leaves the block waiting for release
  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (item_xfer && res_new.action == ufr_pkg::ACT_DONE) |=> phase == ufr_pkg::PH_HOLD)
    else $error("no hold after frame complete");

endmodule

`default_nettype wire

// ===== dv/uart_frame_receiver_crc8_tb.sv =====
// self-checking testbench for the byte-stuffed frame receiver with crc-8/maxim
// depends on ufr_pkg, the channel interfaces in ufr_if.sv and the top level
// stimulus: directed frames, then random well-formed, broken and noisy traffic
module uart_frame_receiver_crc8_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ufr_pkg::*;

  localparam int CYCLE_LIMIT = 150000;
  localparam int LONG_HOLD   = 300;
  localparam int HOLD_AT     = 500;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } rx_item_t;

  typedef logic [7:0] byte_q_t[$];

  logic clk;
  logic rst;

  ufr_item_if   item_ch ();
  ufr_result_if result_ch ();
  ufr_cfg_if    cfg_ch ();

  uart_frame_receiver_crc8 dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .item   (item_ch),
    .result (result_ch)
  );

  // queues between stimulus, driver and checker
  rx_item_t pending_bytes[$];
  result_t  expected_results[$];

  int mismatch_count = 0;
  int results_seen   = 0;
  int cycle_count    = 0;
  int gen_count      = 0;

  // idling controls, set per phase while the block is idle
  bit          steady_tx   = 1'b1;
  int          rx_mode     = 0;
  logic [15:0] stall_pattern = 16'hFFFF;

  // frame tracking copy of the block state
  phase_t     rx_phase     = PH_HUNT;
  logic [7:0] rx_pos       = '0;
  logic [7:0] rx_len       = '0;
  logic [7:0] rx_crc       = '0;
  logic       rx_esc       = 1'b0;
  logic       rx_crc_ok    = 1'b0;
  logic [7:0] rx_decoded   = '0;
  logic       crc_check_en = 1'b1;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // crc-8/maxim, one message bit per iteration, lsb first
  function automatic logic [7:0] crc_byte_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = {1'b0, c[7:1]};
      if (fb) c = c ^ 8'h8C;
    end
    return c;
  endfunction

  task automatic clear_frame_state();
    rx_pos     = '0;
    rx_len     = '0;
    rx_crc     = '0;
    rx_esc     = 1'b0;
    rx_crc_ok  = 1'b0;
    rx_decoded = '0;
  endtask

  // advance the frame state by one accepted item and form its result
  task automatic predict_frame_result(input op_t op, input logic [7:0] b, output result_t r);
    r = '0;
    if (op == OP_RELEASE) begin
      rx_phase = PH_HUNT;
      clear_frame_state();
    end else begin
      case (rx_phase)
        PH_RECV: begin
          rx_pos = rx_pos + 8'd1;
          if (rx_pos == 8'd1) begin
            // length byte, out of range ends the frame at once
            if (b < MIN_LEN || b > MAX_LEN) begin
              r.frame_status = ST_FRAMING;
              rx_phase = PH_HUNT;
              clear_frame_state();
            end else begin
              rx_len = b;
              rx_crc = crc_byte_step(8'h00, b);
              r.action = ACT_RESTART;
            end
          end else if (rx_pos < rx_len) begin
            // data byte with on-the-fly unescaping
            rx_crc = crc_byte_step(rx_crc, b);
            if (rx_esc) begin
              rx_esc = 1'b0;
              r.payload_valid = 1'b1;
              r.payload_byte  = b | ESC_MASK;
            end else if (b == ESC_BYTE) begin
              rx_esc = 1'b1;
            end else begin
              r.payload_valid = 1'b1;
              r.payload_byte  = b;
            end
            if (r.payload_valid) rx_decoded = rx_decoded + 8'd1;
            r.action = ACT_RESTART;
          end else if (rx_pos == rx_len) begin
            rx_crc_ok = (b == rx_crc);
            r.action = ACT_RESTART;
          end else begin
            // stop byte
            r.payload_length = rx_decoded;
            if (b == STOP_BYTE) begin
              r.action = ACT_DONE;
              r.frame_status = (crc_check_en && !rx_crc_ok) ? ST_CRC_BAD : ST_OK;
              rx_phase = PH_HOLD;
            end else begin
              r.frame_status = ST_FRAMING;
              rx_phase = PH_HUNT;
              clear_frame_state();
            end
          end
        end
        PH_HOLD: begin
          // bytes ignored until release
        end
        default: begin
          rx_phase = PH_HUNT;
          if (b == START_BYTE) begin
            clear_frame_state();
            rx_phase = PH_RECV;
            r.action = ACT_RESTART;
          end
        end
      endcase
    end
  endtask

  // item driver: bursts of transfers, with random gaps when steady_tx is clear
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin : drive_items
    rx_item_t nxt;
    result_t  want;
    if (rst) begin
      item_ch.valid <= 1'b0;
      item_ch.operation <= OP_BYTE;
      item_ch.rx_byte <= 8'h00;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        predict_frame_result(op_t'(item_ch.operation), item_ch.rx_byte, want);
        expected_results.push_back(want);
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          item_ch.valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          nxt = pending_bytes.pop_front();
          item_ch.valid <= 1'b1;
          item_ch.operation <= nxt.op;
          item_ch.rx_byte <= nxt.data;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 32);
            if (steady_tx || $urandom_range(0, 2) == 0) gap_left <= 0;
            else gap_left <= $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result receiver: stall pattern per phase plus one long hold-off
  int  hold_left  = 0;
  bit  hold_taken = 1'b0;
  logic [3:0] rx_tick = '0;

  always @(posedge clk) begin
    rx_tick <= rx_tick + 4'd1;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      result_ch.ready <= 1'b0;
    end else if (!hold_taken && results_seen >= HOLD_AT) begin
      hold_taken <= 1'b1;
      hold_left <= LONG_HOLD;
      result_ch.ready <= 1'b0;
    end else begin
      case (rx_mode)
        1:       result_ch.ready <= stall_pattern[rx_tick];
        2:       result_ch.ready <= ($urandom_range(0, 3) != 0);
        default: result_ch.ready <= 1'b1;
      endcase
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // result checker against the oldest expectation
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual action %0h",
                 $time, result_ch.action);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("action", 8'(want.action), 8'(result_ch.action));
        check_field("payload_valid", 8'(want.payload_valid), 8'(result_ch.payload_valid));
        check_field("payload_byte", want.payload_byte, result_ch.payload_byte);
        check_field("frame_status", 8'(want.frame_status), 8'(result_ch.frame_status));
        check_field("payload_length", want.payload_length, result_ch.payload_length);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // stimulus helpers
  task automatic push_byte(input logic [7:0] b);
    pending_bytes.push_back('{op: OP_BYTE, data: b});
    gen_count++;
  endtask

  task automatic push_release();
    pending_bytes.push_back('{op: OP_RELEASE, data: 8'($urandom_range(0, 255))});
    gen_count++;
  endtask

  // start, length, raw data, crc (optionally corrupted), stop (optionally wrong)
  task automatic push_frame(input byte_q_t raw, input bit bad_crc, input bit bad_stop);
    logic [7:0] len;
    logic [7:0] crc;
    logic [7:0] stop;
    len = 8'(raw.size() + 2);
    crc = crc_byte_step(8'h00, len);
    push_byte(START_BYTE);
    push_byte(len);
    foreach (raw[i]) begin
      crc = crc_byte_step(crc, raw[i]);
      push_byte(raw[i]);
    end
    if (bad_crc) crc = crc ^ 8'($urandom_range(1, 255));
    push_byte(crc);
    stop = STOP_BYTE;
    if (bad_stop) begin
      stop = 8'($urandom_range(0, 255));
      if (stop == STOP_BYTE) stop = 8'h00;
    end
    push_byte(stop);
  endtask

  function automatic logic [7:0] pick_raw_byte();
    case ($urandom_range(0, 9))
      0, 1:    return ESC_BYTE;
      2:       return START_BYTE;
      3:       return STOP_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic directed_frames();
    byte_q_t raw;
    push_release();
    push_byte(8'h00);
    push_byte(8'hFF);
    // length below minimum and above maximum
    push_byte(START_BYTE);
    push_byte(8'd1);
    push_byte(START_BYTE);
    push_byte(MAX_LEN + 8'd1);
    // shortest frame, no data bytes, then a byte ignored while held
    raw.delete();
    push_frame(raw, 1'b0, 1'b0);
    push_byte(8'hFF);
    push_release();
    // escaped byte followed by an escape as the last data byte
    raw = '{ESC_BYTE, 8'h55, ESC_BYTE};
    push_frame(raw, 1'b0, 1'b0);
    push_release();
    // crc mismatch
    raw = '{8'h12};
    push_frame(raw, 1'b1, 1'b0);
    push_release();
    // bad stop byte
    raw = '{8'h34};
    push_frame(raw, 1'b0, 1'b1);
  endtask

  // mostly complete frames with random content, the rest broken or noise
  task automatic random_traffic(input int n);
    byte_q_t raw;
    int      kind;
    int      len;
    int      cut;
    bit      bad_crc;
    bit      bad_stop;
    gen_count = 0;
    while (gen_count < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        len = ($urandom_range(0, 19) == 0) ? int'(MAX_LEN) : $urandom_range(2, 12);
        raw.delete();
        for (int i = 0; i < len - 2; i++) raw.push_back(pick_raw_byte());
        bad_crc  = ($urandom_range(0, 3) == 0);
        bad_stop = ($urandom_range(0, 9) == 0);
        push_frame(raw, bad_crc, bad_stop);
        // bytes that land while waiting for release are not counted
        if (!bad_stop && $urandom_range(0, 2) == 0) begin
          repeat ($urandom_range(1, 3))
            pending_bytes.push_back('{op: OP_BYTE, data: 8'($urandom_range(0, 255))});
        end
        if (!bad_stop || $urandom_range(0, 1) == 0) push_release();
      end else if (kind < 75) begin
        push_byte(START_BYTE);
        if ($urandom_range(0, 1) == 0) push_byte(8'($urandom_range(0, 1)));
        else push_byte(8'($urandom_range(int'(MAX_LEN) + 1, 255)));
      end else if (kind < 88) begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) < 7) push_release();
      end else begin
        // frame cut short by a release
        len = $urandom_range(2, 12);
        cut = $urandom_range(0, len);
        push_byte(START_BYTE);
        push_byte(8'(len));
        for (int i = 0; i < cut; i++) push_byte(pick_raw_byte());
        push_release();
      end
    end
  endtask

  // wait until every item is sent and every result has been checked
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_bytes.size() != 0 || item_ch.valid || expected_results.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_check_crc(input logic v);
    @(posedge clk);
    cfg_ch.check_crc <= v;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ch.ready);
    crc_check_en = v;
    cfg_ch.valid <= 1'b0;
  endtask

  // main sequence
  initial begin
    rst = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.check_crc = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed part with the reset setting of the crc check
    steady_tx = 1'b1;
    rx_mode = 0;
    directed_frames();
    wait_drained();

    write_check_crc(1'b0);
    steady_tx = 1'b0;
    rx_mode = 2;
    random_traffic(330);
    wait_drained();

    // long hold-off of the receiver lands in this phase
    write_check_crc(1'b1);
    stall_pattern = 16'($urandom_range(0, 65535)) | 16'h0001;
    rx_mode = 1;
    random_traffic(330);
    wait_drained();

    write_check_crc(1'b0);
    rx_mode = 2;
    random_traffic(200);
    wait_drained();

    write_check_crc(1'b1);
    steady_tx = 1'b1;
    rx_mode = 0;
    random_traffic(160);
    wait_drained();

    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ufr_pkg.sv
rtl/ufr_if.sv
rtl/uart_frame_receiver_crc8.sv
dv/uart_frame_receiver_crc8_tb.sv
